>>> hdl/gcd_lcm_unit_defines.svh
// Assertion macros for the gcd_lcm_unit RTL.
// No dependencies; included by modules that carry assertions.
`ifndef GCD_LCM_UNIT_DEFINES_SVH
`define GCD_LCM_UNIT_DEFINES_SVH

// Same-cycle implication.
`define GCDL_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GCDL_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/gcdl_pkg.sv
// Shared types and constants for the gcd/lcm unit.
// No dependencies.
`default_nettype none

package gcdl_pkg;

    localparam int unsigned OPERAND_WIDTH_DEF = 32;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_GCD_ZERO = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW = 2'd2;

    typedef enum logic {
        GCDL_OP_DIV,
        GCDL_OP_MUL
    } gcdl_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EUCLID,
        ST_REM_WAIT,
        ST_QUO_WAIT,
        ST_MUL,
        ST_MUL_WAIT,
        ST_FINISH
    } gcdl_state_t;

    typedef struct packed {
        logic     start;
        gcdl_op_t op;
    } gcdl_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } gcdl_rsp_t;

endpackage

`default_nettype wire

>>> hdl/gcdl_serial_unit.sv
// Shared bit-serial unit: restoring unsigned divide or shift-add multiply, one bit per cycle.
// Depends on gcdl_pkg and gcd_lcm_unit_defines.svh.
`default_nettype none
`include "gcd_lcm_unit_defines.svh"

module gcdl_serial_unit #(
    parameter int unsigned OPERAND_WIDTH = gcdl_pkg::OPERAND_WIDTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire gcdl_pkg::gcdl_cmd_t      cmd,
    input  wire logic [OPERAND_WIDTH-1:0] opa,
    input  wire logic [OPERAND_WIDTH-1:0] opb,
    output gcdl_pkg::gcdl_rsp_t           rsp,
    output logic [OPERAND_WIDTH-1:0]      res_hi,
    output logic [OPERAND_WIDTH-1:0]      res_lo
);

    localparam int unsigned W  = OPERAND_WIDTH;
    localparam int unsigned CW = $clog2(OPERAND_WIDTH);
    localparam logic [CW-1:0] CNT_LAST = CW'(OPERAND_WIDTH - 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    gcdl_pkg::gcdl_op_t  op_reg, op_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [W-1:0]        hi_reg, hi_next;
    logic [W-1:0]        lo_reg, lo_next;
    logic [W-1:0]        opb_reg, opb_next;

    logic [W:0]          shift_in;
    logic [W:0]          add_a;
    logic [W:0]          add_b;
    logic                add_ci;
    logic [W+1:0]        add_full;

    // one shared adder: subtract for divide, accumulate for multiply
    always_comb
    begin
        shift_in = {hi_reg, lo_reg[W-1]};
        if (op_reg == gcdl_pkg::GCDL_OP_DIV)
        begin
            add_a  = shift_in;
            add_b  = ~{1'b0, opb_reg};
            add_ci = 1'b1;
        end
        else
        begin
            add_a  = {1'b0, hi_reg};
            add_b  = lo_reg[0] ? {1'b0, opb_reg} : '0;
            add_ci = 1'b0;
        end
        add_full = {1'b0, add_a} + {1'b0, add_b} + {{(W+1){1'b0}}, add_ci};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        opb_next  = opb_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            op_next   = cmd.op;
            cnt_next  = '0;
            hi_next   = '0;
            lo_next   = opa;
            opb_next  = opb;
        end
        else if (busy_reg)
        begin
            if (op_reg == gcdl_pkg::GCDL_OP_DIV)
            begin
                if (add_full[W+1])
                begin
                    hi_next = add_full[W-1:0];
                    lo_next = {lo_reg[W-2:0], 1'b1};
                end
                else
                begin
                    hi_next = shift_in[W-1:0];
                    lo_next = {lo_reg[W-2:0], 1'b0};
                end
            end
            else
            begin
                hi_next = add_full[W:1];
                lo_next = {add_full[0], lo_reg[W-1:1]};
            end
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= gcdl_pkg::GCDL_OP_DIV;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        opb_reg <= opb_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign res_hi   = hi_reg;
    assign res_lo   = lo_reg;

    `GCDL_ASSERT_IMPL(a_start_when_idle, clk, rst_n, cmd.start, !busy_reg, "start while busy")
    `GCDL_ASSERT_NEXT(a_start_goes_busy, clk, rst_n, cmd.start, busy_reg, "start not taken")
    `GCDL_ASSERT_IMPL(a_done_not_busy, clk, rst_n, done_reg, !busy_reg, "done while busy")
    `GCDL_ASSERT_IMPL(a_rem_below_div, clk, rst_n, done_reg && (op_reg == gcdl_pkg::GCDL_OP_DIV),
                      hi_reg < opb_reg, "remainder not below divisor")

endmodule

`default_nettype wire

>>> hdl/gcd_lcm_unit.sv
// gcd_lcm_unit: Euclid gcd (truncating remainder) and multiple (a / gcd) * b.
// Depends on gcdl_pkg, gcdl_serial_unit and gcd_lcm_unit_defines.svh.
//
// Usage:
//   Input channel in_valid/in_ready carries first_value and second_value; the low
//   OPERAND_WIDTH bits of each are taken as two's complement. Output channel
//   out_valid/out_ready carries common_divisor, common_multiple and status
//   (0 ok, 1 gcd zero, 2 quotient overflow; multiple is 0 when status is nonzero).
//   One item at a time: in_ready is high only while the sequencer is idle.
//   Sequence: every Euclid step is one pass of the bit-serial divider; then one divide
//   and one multiply pass of the same unit. Euclid steps are at most 46 for 32-bit
//   operands; a zero gcd or a quotient overflow skips both passes. The next item
//   can be taken in the cycle after the result is loaded. The result sits in an output
//   register; a new item is taken while it waits, and the next result is held in the
//   sequencer until out_ready frees that register.
//   Reset clears the sequencer and the output valid; no item is in flight after it.
`default_nettype none
`include "gcd_lcm_unit_defines.svh"

module gcd_lcm_unit #(
    parameter int unsigned OPERAND_WIDTH = gcdl_pkg::OPERAND_WIDTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] first_value,
    input  wire logic [31:0] second_value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      common_divisor,
    output logic [63:0]      common_multiple,
    output logic [1:0]       status
);

    localparam int unsigned W = OPERAND_WIDTH;
    localparam logic [W-1:0] MIN_MAG = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] ONE_MAG = W'(1);

    gcdl_pkg::gcdl_state_t state_reg, state_next;

    logic [W-1:0] amag_reg, bmag_reg, xmag_reg, ymag_reg;
    logic         sa_reg, sb_reg, sx_reg, sy_reg;

    logic         out_valid_reg;
    logic [31:0]  divisor_reg;
    logic [63:0]  multiple_reg;
    logic [1:0]   status_reg;

    logic [W-1:0] fa, fb, fa_mag, fb_mag;
    logic         in_acc;
    logic         gcd_zero, quo_ovf;
    logic         load_out;
    logic [1:0]   fin_status;
    logic [31:0]  fin_divisor;
    logic [63:0]  prod_mag, fin_multiple;

    gcdl_pkg::gcdl_cmd_t unit_cmd;
    gcdl_pkg::gcdl_rsp_t unit_rsp;
    logic [W-1:0]        unit_opa, unit_opb, unit_hi, unit_lo;

    gcdl_serial_unit #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_serial (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (unit_cmd),
        .opa   (unit_opa),
        .opb   (unit_opb),
        .rsp   (unit_rsp),
        .res_hi(unit_hi),
        .res_lo(unit_lo)
    );

    always_comb
    begin
        fa     = first_value[W-1:0];
        fb     = second_value[W-1:0];
        fa_mag = fa[W-1] ? (~fa) + ONE_MAG : fa;
        fb_mag = fb[W-1] ? (~fb) + ONE_MAG : fb;
        in_acc = in_valid && in_ready;

        gcd_zero = (xmag_reg == '0);
        quo_ovf  = sx_reg && (xmag_reg == ONE_MAG) && sa_reg && (amag_reg == MIN_MAG);

        if (gcd_zero)
            fin_status = gcdl_pkg::STAT_GCD_ZERO;
        else if (quo_ovf)
            fin_status = gcdl_pkg::STAT_OVERFLOW;
        else
            fin_status = gcdl_pkg::STAT_OK;

        fin_divisor = sx_reg ? 32'd0 - 32'(xmag_reg) : 32'(xmag_reg);
        prod_mag    = 64'({unit_hi, unit_lo});
        if (fin_status != gcdl_pkg::STAT_OK)
            fin_multiple = '0;
        else if (sa_reg ^ sx_reg ^ sb_reg)
            fin_multiple = 64'd0 - prod_mag;
        else
            fin_multiple = prod_mag;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gcdl_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = gcdl_pkg::ST_EUCLID;
            end
            gcdl_pkg::ST_EUCLID:
            begin
                if (ymag_reg != '0)
                    state_next = gcdl_pkg::ST_REM_WAIT;
                else if (gcd_zero || quo_ovf)
                    state_next = gcdl_pkg::ST_FINISH;
                else
                    state_next = gcdl_pkg::ST_QUO_WAIT;
            end
            gcdl_pkg::ST_REM_WAIT:
            begin
                if (unit_rsp.done)
                    state_next = gcdl_pkg::ST_EUCLID;
            end
            gcdl_pkg::ST_QUO_WAIT:
            begin
                if (unit_rsp.done)
                    state_next = gcdl_pkg::ST_MUL;
            end
            gcdl_pkg::ST_MUL:
            begin
                state_next = gcdl_pkg::ST_MUL_WAIT;
            end
            gcdl_pkg::ST_MUL_WAIT:
            begin
                if (unit_rsp.done)
                    state_next = gcdl_pkg::ST_FINISH;
            end
            gcdl_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = gcdl_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = gcdl_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready       = 1'b0;
        load_out       = 1'b0;
        unit_cmd.start = 1'b0;
        unit_cmd.op    = gcdl_pkg::GCDL_OP_DIV;
        unit_opa       = xmag_reg;
        unit_opb       = ymag_reg;
        case (state_reg)
            gcdl_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            gcdl_pkg::ST_EUCLID:
            begin
                if (ymag_reg != '0)
                begin
                    unit_cmd.start = 1'b1;
                end
                else if (!(gcd_zero || quo_ovf))
                begin
                    unit_cmd.start = 1'b1;
                    unit_opa       = amag_reg;
                    unit_opb       = xmag_reg;
                end
            end
            gcdl_pkg::ST_MUL:
            begin
                unit_cmd.start = 1'b1;
                unit_cmd.op    = gcdl_pkg::GCDL_OP_MUL;
                unit_opa       = ymag_reg;
                unit_opb       = bmag_reg;
            end
            gcdl_pkg::ST_FINISH:
            begin
                load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gcdl_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            amag_reg <= fa_mag;
            bmag_reg <= fb_mag;
            sa_reg   <= fa[W-1];
            sb_reg   <= fb[W-1];
            xmag_reg <= fa_mag;
            ymag_reg <= fb_mag;
            sx_reg   <= fa[W-1];
            sy_reg   <= fb[W-1];
        end
        else if ((state_reg == gcdl_pkg::ST_REM_WAIT) && unit_rsp.done)
        begin
            // (x, y) <- (y, x rem y); remainder sign follows x
            xmag_reg <= ymag_reg;
            ymag_reg <= unit_hi;
            sx_reg   <= sy_reg;
            sy_reg   <= sx_reg;
        end
        else if ((state_reg == gcdl_pkg::ST_QUO_WAIT) && unit_rsp.done)
        begin
            ymag_reg <= unit_lo;
        end
        if (load_out)
        begin
            divisor_reg  <= fin_divisor;
            multiple_reg <= fin_multiple;
            status_reg   <= fin_status;
        end
    end

    assign out_valid       = out_valid_reg;
    assign common_divisor  = divisor_reg;
    assign common_multiple = multiple_reg;
    assign status          = status_reg;

    `GCDL_ASSERT_IMPL(a_idle_unit_free, clk, rst_n, state_reg == gcdl_pkg::ST_IDLE,
                      !unit_rsp.busy, "serial unit busy while idle")
    `GCDL_ASSERT_IMPL(a_bad_status_zero, clk, rst_n,
                      out_valid_reg && (status_reg != gcdl_pkg::STAT_OK),
                      multiple_reg == 64'd0, "multiple nonzero with bad status")
    `GCDL_ASSERT_IMPL(a_zero_gcd_status, clk, rst_n, out_valid_reg,
                      (divisor_reg == 32'd0) == (status_reg == gcdl_pkg::STAT_GCD_ZERO),
                      "zero gcd and status disagree")
    `GCDL_ASSERT_IMPL(a_ovf_minus_one, clk, rst_n,
                      out_valid_reg && (status_reg == gcdl_pkg::STAT_OVERFLOW),
                      divisor_reg == 32'hFFFF_FFFF, "overflow without gcd of minus one")

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for gcd_lcm_unit: directed and random operand pairs,
// with every result checked against a built-in gcd/lcm predictor.
// Depends on gcdl_pkg and the gcd_lcm_unit RTL.
`default_nettype none

module tb;

    localparam int unsigned OPERAND_WIDTH = gcdl_pkg::OPERAND_WIDTH_DEF;
    localparam int MOST_NEGATIVE = int'(32'h8000_0000);
    localparam int MOST_POSITIVE = int'(32'h7FFF_FFFF);
    localparam int FIB_45 = 1134903170;
    localparam int FIB_46 = 1836311903;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        logic [31:0] first_op;
        logic [31:0] second_op;
        logic [31:0] divisor;
        logic [63:0] multiple;
        logic [1:0]  code;
    } gcd_lcm_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] first_value;
    logic [31:0] second_value;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] common_divisor;
    logic [63:0] common_multiple;
    logic [1:0]  status;

    gcd_lcm_unit #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .first_value(first_value),
        .second_value(second_value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .common_divisor(common_divisor),
        .common_multiple(common_multiple),
        .status(status)
    );

    gcd_lcm_result_t pending_results[$];
    int              mismatch_count = 0;
    bit              idle_enable = 1'b1;
    int              hold_cycles = 0;
    int              special_values[9] = '{0, 1, -1, 2, -2, MOST_NEGATIVE, MOST_POSITIVE,
                                           MOST_NEGATIVE + 1, MOST_POSITIVE - 1};

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Low OPERAND_WIDTH bits, read as two's complement.
    function automatic longint take_low_bits(logic [31:0] raw);
        logic [63:0] v;
        v = 64'(raw) & ((64'd1 << OPERAND_WIDTH) - 64'd1);
        if (v[OPERAND_WIDTH-1])
            v = v - (64'd1 << OPERAND_WIDTH);
        return longint'(v);
    endfunction

    function automatic gcd_lcm_result_t compute_gcd_lcm(logic [31:0] a_raw, logic [31:0] b_raw);
        longint          a;
        longint          b;
        longint          x;
        longint          y;
        longint          r;
        longint          lowest;
        gcd_lcm_result_t res;
        a = take_low_bits(a_raw);
        b = take_low_bits(b_raw);
        lowest = -(64'sd1 <<< (OPERAND_WIDTH - 1));
        x = a;
        y = b;
        while (y != 0)
        begin
            r = x % y;
            x = y;
            y = r;
        end
        res.first_op = a_raw;
        res.second_op = b_raw;
        res.divisor = x[31:0];
        res.multiple = '0;
        if (x == 0)
            res.code = gcdl_pkg::STAT_GCD_ZERO;
        else if (x == -1 && a == lowest)
            res.code = gcdl_pkg::STAT_OVERFLOW;
        else
        begin
            res.code = gcdl_pkg::STAT_OK;
            res.multiple = (a / x) * b;
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idle_enable)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    function automatic int random_sign(int v);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Valid stays high after acceptance; it is lowered only when a gap follows.
    task automatic send_operands(input int a, input int b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        first_value <= a;
        second_value <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(compute_gcd_lcm(a, b));
    endtask

    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_enable && hold_cycles > 0)
            begin
                hold_cycles--;
                out_ready <= 1'b0;
            end
            else
            begin
                hold_cycles = 0;
                out_ready <= 1'b1;
                if (idle_enable && $urandom_range(0, 9) < 2)
                    hold_cycles = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        gcd_lcm_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected item: gcd %0d lcm %0d status %0d",
                    $signed(common_divisor), $signed(common_multiple), status));
            else
            begin
                want = pending_results.pop_front();
                if (common_divisor !== want.divisor)
                    report_mismatch($sformatf("a=%0d b=%0d gcd got %0d want %0d",
                        $signed(want.first_op), $signed(want.second_op),
                        $signed(common_divisor), $signed(want.divisor)));
                if (common_multiple !== want.multiple)
                    report_mismatch($sformatf("a=%0d b=%0d lcm got %0d want %0d",
                        $signed(want.first_op), $signed(want.second_op),
                        $signed(common_multiple), $signed(want.multiple)));
                if (status !== want.code)
                    report_mismatch($sformatf("a=%0d b=%0d status got %0d want %0d",
                        $signed(want.first_op), $signed(want.second_op), status, want.code));
            end
        end
    end

    task automatic drive_random_operands(input int count);
        int a;
        int b;
        int k;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    a = int'($urandom());
                    b = int'($urandom());
                end
                3, 4:
                begin
                    k = $urandom_range(1, 32768);
                    a = random_sign(k * int'($urandom_range(0, 65535)));
                    b = random_sign(k * int'($urandom_range(0, 65535)));
                end
                5:
                begin
                    a = int'($urandom_range(0, 128)) - 64;
                    b = int'($urandom_range(0, 128)) - 64;
                end
                6:
                begin
                    b = int'($urandom_range(0, 2097152)) - 1048576;
                    a = b * (int'($urandom_range(0, 2000)) - 1000);
                end
                7:
                begin
                    a = special_values[$urandom_range(0, 8)];
                    b = int'($urandom());
                    if ($urandom_range(0, 1))
                    begin
                        k = a;
                        a = b;
                        b = k;
                    end
                end
                default:
                begin
                    a = int'($urandom() | 32'hC000_0000);
                    b = int'($urandom() | 32'h8000_0000);
                    if ($urandom_range(0, 1))
                        b = random_sign(int'($urandom_range(1, 1000)));
                end
            endcase
            send_operands(a, b);
        end
    endtask

    task automatic test_zero_operands();
        send_operands(0, 0);
        send_operands(0, 7);
        send_operands(7, 0);
        send_operands(0, MOST_NEGATIVE);
        send_operands(MOST_NEGATIVE, 0);
        send_operands(0, -1);
    endtask

    task automatic test_quotient_overflow();
        send_operands(MOST_NEGATIVE, -1);
        send_operands(MOST_NEGATIVE, -3);
        send_operands(MOST_NEGATIVE, MOST_NEGATIVE + 1);
        send_operands(MOST_NEGATIVE, 3);
        send_operands(MOST_NEGATIVE, 1);
        send_operands(-1, MOST_NEGATIVE);
    endtask

    task automatic test_extremes();
        send_operands(MOST_POSITIVE, MOST_POSITIVE);
        send_operands(MOST_POSITIVE, MOST_NEGATIVE);
        send_operands(MOST_NEGATIVE, MOST_POSITIVE);
        send_operands(MOST_NEGATIVE, MOST_NEGATIVE);
        send_operands(MOST_POSITIVE, -1);
        send_operands(1, -1);
        send_operands(-1, -1);
        // longest Euclid chains
        send_operands(FIB_46, FIB_45);
        send_operands(-FIB_46, FIB_45);
        send_operands(FIB_45, -FIB_46);
        send_operands(12, -18);
        send_operands(-12, -18);
    endtask

    task automatic test_back_to_back();
        idle_enable = 1'b0;
        drive_random_operands(40);
        idle_enable = 1'b1;
    endtask

    task automatic test_random_mix();
        drive_random_operands(310);
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        first_value <= '0;
        second_value <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_operands();
        test_quotient_overflow();
        test_extremes();
        test_back_to_back();
        test_random_mix();
        wait_for_drain();

        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d items never came out", pending_results.size()));
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
